/* hw/rtl/reset_fade_sequencer_core_macros.svh */
// Assertion helpers for the reset/fade sequencer.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef RESET_FADE_SEQUENCER_CORE_MACROS_SVH
`define RESET_FADE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication.
`define RFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rfs_pkg.sv */
`timescale 1ns / 1ps

package rfs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int LEN_W   = 24;
    localparam int EXTRA_W = 16;
    localparam int SAMP_W  = 16;
    localparam int CNT_W   = 26;
    localparam int ALPHA_W = 17;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = ALPHA_W'(65536);

    localparam logic [LEN_W-1:0]   FADE_LEN_RST  = LEN_W'(1234567);
    localparam logic [LEN_W-1:0]   STALL_LEN_RST = LEN_W'(101 * (2 << 14));
    localparam logic [EXTRA_W-1:0] EXTRA_RST     = '0;
    localparam logic               SGB_RST       = 1'b0;

    localparam logic [1:0] MODE_REQ = 2'd0;
    localparam logic [1:0] MODE_ADV = 2'd1;
    localparam logic [1:0] MODE_PIX = 2'd2;
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_LEN  = 2'd0,
        CFG_STALL_LEN = 2'd1,
        CFG_EXTRA     = 2'd2,
        CFG_SGB       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_REQ,
        K_ADV,
        K_PIX,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        STG_IDLE  = 2'd0,
        STG_FADE  = 2'd1,
        STG_STALL = 2'd2
    } t_stage;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PREP,
        BS_CHK,
        BS_DIV,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SAMP_W-1:0] requested_samples;
        logic [31:0]       pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [SAMP_W-1:0]  granted_samples;
        logic [PIX_W-1:0]   pixel_out;
        logic [ALPHA_W-1:0] alpha;
        logic               fade_applied;
        logic               mute_audio;
        logic               reset_pulse;
        logic               resetting;
    } t_out_item;

    // classified command between front and back
    typedef struct packed {
        t_kind             kind;
        logic [SAMP_W-1:0] req;
        logic [PIX_W-1:0]  pix;
    } t_cmd;

endpackage

/* hw/rtl/rfs_front.sv */
`timescale 1ns / 1ps

module rfs_front import rfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_push,
    output t_cmd     o_push_data,
    input  logic     i_q_full
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  cls;
    logic  accept;

    always_comb begin
        cls.req = i_in_data.requested_samples;
        cls.pix = i_in_data.pixel_in[PIX_W-1:0];
        unique case (i_in_data.mode)
            MODE_REQ: cls.kind = K_REQ;
            MODE_ADV: cls.kind = K_ADV;
            MODE_PIX: cls.kind = K_PIX;
            MODE_NOP: cls.kind = K_NOP;
            default:  cls.kind = K_NOP;
        endcase
    end

    assign o_in_stall  = r_valid && i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_q_full;
    assign o_push_data = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cls;
        end
    end

endmodule

/* hw/rtl/rfs_queue.sv */
`timescale 1ns / 1ps

module rfs_queue import rfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    output logic o_pop_valid,
    output t_cmd o_pop_data,
    input  logic i_pop
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_pop;

    assign o_full      = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/rfs_back.sv */
`timescale 1ns / 1ps

module rfs_back import rfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int NINE_W = CNT_W + 4;
    localparam int DEN_W  = LEN_W + 3;
    localparam int BIT_W  = 4;

    function automatic logic [CH_W-1:0] dim_ch(input logic [CH_W-1:0] ch,
                                               input logic [ALPHA_W-1:0] a);
        logic [CH_W+ALPHA_W-1:0] p;
        p = (CH_W + ALPHA_W)'(ch) * (CH_W + ALPHA_W)'(a);
        return p[CH_W+15:16];
    endfunction

    // configuration
    logic [LEN_W-1:0]   r_fade_len;
    logic [LEN_W-1:0]   r_stall_len;
    logic [EXTRA_W-1:0] r_extra;
    logic               r_sgb;
    logic [CNT_W-1:0]   r_start_cd;
    logic [DEN_W-1:0]   r_den7;

    // sequencer state
    t_stage             r_stage;
    logic [CNT_W-1:0]   r_countdown;
    logic               r_pending;
    logic               r_busy;
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_fade_active;

    // per-advance scratch
    logic [SAMP_W-1:0]  r_granted;
    logic               r_pulse;
    logic               r_act;
    logic [NINE_W:0]    r_diff;
    logic [DEN_W-1:0]   r_rem;
    logic [15:0]        r_quo;
    logic [BIT_W-1:0]   r_bit_cnt;

    t_bstate            r_bstate;
    t_bstate            n_bstate;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               out_free;
    logic               take;
    logic               is_adv;
    logic               out_load;
    logic               fin_adv;

    // advance update
    logic               start;
    t_stage             stg_a;
    logic [CNT_W-1:0]   cd_a;
    logic [SAMP_W-1:0]  granted;
    logic               act;
    logic [CNT_W-1:0]   cd_b;
    t_stage             n_stage;
    logic [CNT_W-1:0]   n_countdown;
    logic               n_busy;
    logic               pulse;

    // alpha path
    logic [NINE_W-1:0]  nine_c;
    logic               a_zero;
    logic               a_full;
    logic [DEN_W:0]     rem2;
    logic               q_bit;

    t_out_item          item_out;

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_adv   = (i_cmd.kind == K_ADV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_len  <= FADE_LEN_RST;
            r_stall_len <= STALL_LEN_RST;
            r_extra     <= EXTRA_RST;
            r_sgb       <= SGB_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FADE_LEN:  r_fade_len  <= i_cfg_data[LEN_W-1:0];
                CFG_STALL_LEN: r_stall_len <= i_cfg_data[LEN_W-1:0];
                CFG_EXTRA:     r_extra     <= i_cfg_data[EXTRA_W-1:0];
                CFG_SGB:       r_sgb       <= i_cfg_data[0];
                default:       r_sgb       <= r_sgb;
            endcase
        end
    end

    // derived from configuration and registered
    always_ff @(posedge i_clk) begin
        r_start_cd <= CNT_W'(r_fade_len) + CNT_W'(r_extra);
        r_den7     <= {r_fade_len, 3'b000} - DEN_W'(r_fade_len);
    end

    always_comb begin
        start   = (r_stage == STG_IDLE) && r_pending;
        stg_a   = start ? STG_FADE : r_stage;
        cd_a    = start ? r_start_cd : r_countdown;
        // the starting advance is not clamped
        if ((r_stage != STG_IDLE) && (CNT_W'(i_cmd.req) > r_countdown)) begin
            granted = r_countdown[SAMP_W-1:0];
        end else begin
            granted = i_cmd.req;
        end
        act     = (stg_a != STG_IDLE);
        cd_b    = (CNT_W'(granted) >= cd_a) ? '0 : cd_a - CNT_W'(granted);
        n_stage     = stg_a;
        n_countdown = cd_a;
        n_busy      = r_busy || start;
        pulse       = 1'b0;
        if (act) begin
            n_countdown = cd_b;
            if (cd_b == '0) begin
                if (stg_a == STG_FADE) begin
                    pulse       = 1'b1;
                    n_stage     = STG_STALL;
                    n_countdown = CNT_W'(r_stall_len);
                end else begin
                    n_busy      = 1'b0;
                    n_stage     = STG_IDLE;
                    n_countdown = '0;
                end
            end
        end
    end

    // alpha = ((9c - F) << 16) / 7F, clamped
    assign nine_c = NINE_W'({r_countdown, 3'b000}) + NINE_W'(r_countdown);
    assign a_zero = r_diff[NINE_W] || (r_diff == '0);
    assign a_full = (r_fade_len == '0) || (r_diff[NINE_W-1:0] >= NINE_W'(r_den7));
    assign rem2   = {r_rem, 1'b0};
    assign q_bit  = (rem2 >= (DEN_W + 1)'(r_den7));

    always_comb begin
        n_bstate = r_bstate;
        unique case (r_bstate)
            BS_IDLE: begin
                if (take && is_adv) begin
                    n_bstate = BS_PREP;
                end
            end
            BS_PREP: n_bstate = BS_CHK;
            BS_CHK: begin
                if (r_act && (r_stage == STG_FADE) && !a_zero && !a_full) begin
                    n_bstate = BS_DIV;
                end else begin
                    n_bstate = BS_DONE;
                end
            end
            BS_DIV: begin
                if (r_bit_cnt == '0) begin
                    n_bstate = BS_DONE;
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    n_bstate = BS_IDLE;
                end
            end
            default: n_bstate = BS_IDLE;
        endcase
    end

    always_comb begin
        take     = (r_bstate == BS_IDLE) && i_cmd_valid && out_free;
        fin_adv  = (r_bstate == BS_DONE) && out_free;
        out_load = (take && !is_adv) || fin_adv;
    end

    assign o_cmd_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= BS_IDLE;
        end else begin
            r_bstate <= n_bstate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage       <= STG_IDLE;
            r_countdown   <= '0;
            r_pending     <= 1'b0;
            r_busy        <= 1'b0;
            r_alpha       <= ALPHA_FULL;
            r_fade_active <= 1'b0;
        end else begin
            if (take && (i_cmd.kind == K_REQ) && !r_busy) begin
                r_pending <= 1'b1;
            end
            if (take && is_adv) begin
                r_stage     <= n_stage;
                r_countdown <= n_countdown;
                r_busy      <= n_busy;
                if (start) begin
                    r_pending <= 1'b0;
                end
            end
            if (r_bstate == BS_CHK) begin
                r_fade_active <= r_act;
                if (!r_act || ((r_stage == STG_FADE) && !a_zero && a_full)) begin
                    r_alpha <= ALPHA_FULL;
                end else if ((r_stage != STG_FADE) || a_zero) begin
                    r_alpha <= '0;
                end
            end
            if ((r_bstate == BS_DIV) && (r_bit_cnt == '0)) begin
                r_alpha <= {1'b0, r_quo[14:0], q_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_adv) begin
            r_granted <= granted;
            r_pulse   <= pulse;
            r_act     <= act && !r_sgb;
        end
        if (r_bstate == BS_PREP) begin
            r_diff <= {1'b0, nine_c} - (NINE_W + 1)'(r_fade_len);
        end
        if (r_bstate == BS_CHK) begin
            r_rem     <= r_diff[DEN_W-1:0];
            r_quo     <= '0;
            r_bit_cnt <= BIT_W'(15);
        end
        if (r_bstate == BS_DIV) begin
            r_rem     <= q_bit ? DEN_W'(rem2 - (DEN_W + 1)'(r_den7)) : rem2[DEN_W-1:0];
            r_quo     <= {r_quo[14:0], q_bit};
            r_bit_cnt <= r_bit_cnt - BIT_W'(1);
        end
    end

    always_comb begin
        item_out.granted_samples = '0;
        item_out.pixel_out       = '0;
        item_out.alpha           = r_alpha;
        item_out.fade_applied    = r_fade_active;
        item_out.mute_audio      = 1'b0;
        item_out.reset_pulse     = 1'b0;
        item_out.resetting       = r_busy;
        if (r_bstate == BS_DONE) begin
            item_out.granted_samples = r_granted;
            item_out.mute_audio      = r_fade_active && !r_alpha[ALPHA_W-1];
            item_out.reset_pulse     = r_pulse;
        end else if (i_cmd.kind == K_PIX) begin
            if (r_fade_active) begin
                item_out.pixel_out = {dim_ch(i_cmd.pix[23:16], r_alpha),
                                      dim_ch(i_cmd.pix[15:8], r_alpha),
                                      dim_ch(i_cmd.pix[7:0], r_alpha)};
            end else begin
                item_out.pixel_out = i_cmd.pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= item_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/reset_fade_sequencer_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out      out        o_out_valid / i_out_stall  o_out_data (t_out_item)
// cfg      in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Pixels, reset requests, unused codes: one per cycle while the output is free and
// no advance holds the back end; each passes input register, queue, output register.
// Time advance: holds the back end through prepare, check, 16 serial steps and done
// when alpha is divided, and through prepare, check and done when it is not.
// A four-entry queue lets the input side keep taking items while an advance divides.
// Reset (i_rst_n low, synchronous) loads the register defaults, idle stage, alpha full.
// A stalled output holds its result; the back end waits, the queue then fills and
// o_in_stall rises.

module reset_fade_sequencer_core import rfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "reset_fade_sequencer_core_macros.svh"

    logic push;
    t_cmd push_data;
    logic q_full;
    logic pop_valid;
    t_cmd pop_data;
    logic pop;

    rfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_q_full    (q_full)
    );

    rfs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_data),
        .i_pop       (pop)
    );

    rfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_data),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `RFS_ASSERT_NOW(a_pulse_busy, o_out_valid && o_out_data.reset_pulse,
                    o_out_data.resetting, "reset pulse outside a reset sequence")
    `RFS_ASSERT_NOW(a_mute_faded, o_out_valid && o_out_data.mute_audio,
                    o_out_data.fade_applied, "mute without fade")
    `RFS_ASSERT_NOW(a_nofade_full, o_out_valid && !o_out_data.fade_applied,
                    o_out_data.alpha == ALPHA_FULL, "alpha dimmed without fade")
    `RFS_ASSERT_NOW(a_alpha_range, o_out_valid && o_out_data.alpha[ALPHA_W-1],
                    o_out_data.alpha[ALPHA_W-2:0] == '0, "alpha above full")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rfs_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 58;

    // Tracks the sequencer state, predicts one result per input transfer and
    // compares the results in order.
    class fade_seq_scoreboard;
        logic [LEN_W-1:0]   fade_len;
        logic [LEN_W-1:0]   stall_len;
        logic [EXTRA_W-1:0] extra;
        logic               sgb;
        t_stage             stage;
        logic [CNT_W-1:0]   countdown;
        bit                 req_pending;
        bit                 busy;
        logic [ALPHA_W-1:0] alpha;
        bit                 fading;
        t_out_item          pending_results[$];
        int                 errors;
        int                 n_inputs;
        int                 n_checked;
        int                 n_pulses;
        int                 n_completed;

        function new();
            fade_len    = FADE_LEN_RST;
            stall_len   = STALL_LEN_RST;
            extra       = EXTRA_RST;
            sgb         = SGB_RST;
            stage       = STG_IDLE;
            countdown   = '0;
            req_pending = 0;
            busy        = 0;
            alpha       = ALPHA_FULL;
            fading      = 0;
            errors      = 0;
            n_inputs    = 0;
            n_checked   = 0;
            n_pulses    = 0;
            n_completed = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FADE_LEN:  fade_len = val;
                CFG_STALL_LEN: stall_len = val;
                CFG_EXTRA:     extra = val[EXTRA_W-1:0];
                CFG_SGB:       sgb = val[0];
                default: ;
            endcase
        endfunction

        // Q16 brightness from the remaining fade count, clamped to full
        function logic [ALPHA_W-1:0] fade_brightness(logic [CNT_W-1:0] c);
            logic [63:0] nine_c;
            logic [63:0] den;
            logic [63:0] q;
            nine_c = 64'(c) * 64'd9;
            den    = 64'(fade_len) * 64'd7;
            if (nine_c <= 64'(fade_len))
                return '0;
            if (den == 0)
                return ALPHA_FULL;
            q = ((nine_c - 64'(fade_len)) << 16) / den;
            return (q > 64'(ALPHA_FULL)) ? ALPHA_FULL : q[ALPHA_W-1:0];
        endfunction

        function logic [PIX_W-1:0] dim_pixel(logic [31:0] px, logic [ALPHA_W-1:0] a);
            int unsigned r;
            int unsigned g;
            int unsigned b;
            r = (32'(px[23:16]) * 32'(a)) >> 16;
            g = (32'(px[15:8]) * 32'(a)) >> 16;
            b = (32'(px[7:0]) * 32'(a)) >> 16;
            return {r[7:0], g[7:0], b[7:0]};
        endfunction

        function void take_input(t_in_item it);
            t_out_item        res;
            logic [SAMP_W-1:0] grant;
            bit               was_active;
            res = '0;
            n_inputs++;
            case (it.mode)
                MODE_REQ: begin
                    if (!busy)
                        req_pending = 1;
                end
                MODE_ADV: begin
                    grant = it.requested_samples;
                    if (stage == STG_IDLE) begin
                        if (req_pending) begin
                            req_pending = 0;
                            busy        = 1;
                            stage       = STG_FADE;
                            countdown   = CNT_W'(fade_len) + CNT_W'(extra);
                        end
                    end else if (CNT_W'(grant) > countdown) begin
                        grant = countdown[SAMP_W-1:0];
                    end
                    was_active = (stage != STG_IDLE);
                    if (was_active) begin
                        // the starting advance is unclamped, so saturate
                        countdown = (CNT_W'(grant) >= countdown) ? '0
                                                                  : countdown - CNT_W'(grant);
                        if (countdown == 0) begin
                            if (stage == STG_FADE) begin
                                res.reset_pulse = 1'b1;
                                n_pulses++;
                                stage     = STG_STALL;
                                countdown = CNT_W'(stall_len);
                            end else begin
                                busy      = 0;
                                stage     = STG_IDLE;
                                countdown = '0;
                                n_completed++;
                            end
                        end
                    end
                    if (was_active && !sgb) begin
                        fading = 1;
                        alpha  = (stage == STG_FADE) ? fade_brightness(countdown) : '0;
                        res.mute_audio = (alpha < ALPHA_FULL);
                    end else begin
                        fading = 0;
                        alpha  = ALPHA_FULL;
                    end
                    res.granted_samples = grant;
                end
                MODE_PIX: begin
                    res.pixel_out = fading ? dim_pixel(it.pixel_in, alpha)
                                           : it.pixel_in[PIX_W-1:0];
                end
                default: ;
            endcase
            res.alpha        = alpha;
            res.fade_applied = fading;
            res.resetting    = busy;
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void compare(string field, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $time, field, e, a);
                errors++;
            end
        endfunction

        function void check_output(t_out_item got);
            t_out_item exp;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual 0x%0h", $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            n_checked++;
            compare("granted_samples", exp.granted_samples, got.granted_samples);
            compare("pixel_out", exp.pixel_out, got.pixel_out);
            compare("alpha", exp.alpha, got.alpha);
            compare("fade_applied", exp.fade_applied, got.fade_applied);
            compare("mute_audio", exp.mute_audio, got.mute_audio);
            compare("reset_pulse", exp.reset_pulse, got.reset_pulse);
            compare("resetting", exp.resetting, got.resetting);
        endfunction

        function void finish_check();
            if (pending_results.size() != 0) begin
                $display("%0t missing results: expected %0d more actual 0",
                         $time, pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_index = CFG_FADE_LEN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   o_in_stall;
    wire                   o_out_valid;
    t_out_item             o_out_data;

    fade_seq_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          n_phases = 0;

    reset_fade_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall)
                sb.check_output(o_out_data);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    function automatic t_in_item make_item(logic [1:0] m, logic [SAMP_W-1:0] r,
                                           logic [31:0] p);
        t_in_item it;
        it.mode              = m;
        it.requested_samples = r;
        it.pixel_in          = p;
        return it;
    endfunction

    function automatic t_in_item random_item();
        int unsigned       pick;
        logic [1:0]        m;
        logic [SAMP_W-1:0] r;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            m = MODE_REQ;
        else if (pick < 45)
            m = MODE_ADV;
        else if (pick < 95)
            m = MODE_PIX;
        else
            m = MODE_NOP;
        case ($urandom_range(0, 7))
            0:       r = '0;
            1:       r = '1;
            2, 3:    r = SAMP_W'($urandom_range(0, 255));
            default: r = SAMP_W'($urandom);
        endcase
        return make_item(m, r, $urandom);
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.take_input(it);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_item(random_item());
    endtask

    // full-size advances until the running sequence is back in idle
    task automatic finish_sequence();
        while (sb.busy)
            send_item(make_item(MODE_ADV, '1, $urandom));
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [LEN_W-1:0] fade, input logic [LEN_W-1:0] stall,
                                input logic [EXTRA_W-1:0] extra_v, input logic sgb_v);
        t_cfg_idx              order[4];
        logic [CFG_DATA_W-1:0] vals[4];
        order = '{CFG_FADE_LEN, CFG_STALL_LEN, CFG_EXTRA, CFG_SGB};
        vals  = '{fade, stall, CFG_DATA_W'(extra_v), CFG_DATA_W'(sgb_v)};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.write_reg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    task automatic set_profile(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        set_profile(13, 51);

        // register defaults: pass-through while idle, then a fade start
        send_item(make_item(MODE_PIX, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_PIX, '0, 32'h0000_0000));
        send_item(make_item(MODE_ADV, '1, '0));
        send_item(make_item(MODE_ADV, '0, '0));
        send_item(make_item(MODE_NOP, SAMP_W'($urandom), $urandom));
        send_item(make_item(MODE_REQ, '0, '0));
        send_item(make_item(MODE_REQ, '1, '1));
        send_item(make_item(MODE_PIX, '0, 32'h00FF_80FF));
        send_item(make_item(MODE_ADV, '1, '0));
        send_item(make_item(MODE_PIX, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_REQ, '0, '0));
        send_item(make_item(MODE_ADV, '0, '0));
        send_item(make_item(MODE_PIX, '0, 32'h1234_5678));
        finish_sequence();
        wait_quiet();

        // zero fade length with extra samples, then a zero-length stall
        program_regs('0, '0, 16'd100, 1'b0);
        send_item(make_item(MODE_REQ, '0, '0));
        send_item(make_item(MODE_ADV, 16'd10, '0));
        send_item(make_item(MODE_ADV, '1, '0));
        send_item(make_item(MODE_PIX, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_ADV, 16'd3, '0));
        send_item(make_item(MODE_ADV, 16'd3, '0));
        wait_quiet();

        // stages run but nothing is faded
        program_regs(24'd300, 24'd200, 16'd50, 1'b1);
        send_item(make_item(MODE_REQ, '0, '0));
        send_item(make_item(MODE_ADV, '1, '0));
        send_item(make_item(MODE_PIX, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_ADV, 16'd100, '0));
        send_item(make_item(MODE_ADV, '1, '0));
        wait_quiet();

        program_regs(LEN_W'($urandom_range(0, 200000)), LEN_W'($urandom_range(0, 300000)),
                     EXTRA_W'($urandom), 1'b0);
        run_random(PHASE_ITEMS);
        wait_quiet();

        set_profile(51, 13);
        program_regs(LEN_W'($urandom_range(0, 200000)), LEN_W'($urandom_range(0, 300000)),
                     EXTRA_W'($urandom), 1'b1);
        run_random(PHASE_ITEMS);
        wait_quiet();

        program_regs('0, '0, '0, 1'b0);
        run_random(PHASE_ITEMS);
        wait_quiet();

        set_profile(0, 0);
        program_regs(LEN_W'($urandom_range(0, 200000)), LEN_W'($urandom_range(0, 300000)),
                     EXTRA_W'($urandom_range(0, 2000)), 1'b0);
        // long receiver hold while items keep coming, fills the queue
        hold_asked++;
        run_random(PHASE_ITEMS);
        wait_quiet();

        program_regs(LEN_W'($urandom_range(0, 150000)), LEN_W'($urandom_range(0, 150000)),
                     EXTRA_W'($urandom), ($urandom_range(0, 3) == 0));
        run_random(PHASE_ITEMS);
        finish_sequence();
        wait_quiet();

        // widest lengths; the long fade is still running when the run ends
        program_regs('1, '1, '1, 1'b0);
        run_random(PHASE_ITEMS);
        wait_quiet();

        sb.finish_check();
        $display("covered %0d input transfers and %0d checked results over %0d register setups",
                 sb.n_inputs, sb.n_checked, n_phases);
        $display("reset pulses seen: %0d, full reset sequences completed: %0d",
                 sb.n_pulses, sb.n_completed);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
